// ===== rtl/core/salru_pkg.sv =====
// package for the set-associative lru cache model
// shared constants, command and outcome codes, lookup status type; no dependencies
package salru_pkg;

    localparam int MAX_SET_BITS_DEF = 6;
    localparam int MAX_WAYS_DEF     = 8;
    localparam int TAG_WIDTH_DEF    = 32;

    localparam int ADDR_W     = 64;
    localparam int CMD_W      = 2;
    localparam int OUTCOME_W  = 2;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int SBITS_W    = 3;
    localparam int WAYS_W     = 4;
    localparam int BOFF_W     = 5;

    localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;

    localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_FILL  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 2'd2;

    typedef struct packed {
        logic                 hit;
        logic                 fill;
        logic [OUTCOME_W-1:0] outcome;
    } t_look_res;

endpackage

// ===== rtl/core/salru_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module salru_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/salru_way_sel.sv =====
// way selection for one set: hit, fill or victim choice and lru rank update
// depends on salru_pkg
module salru_way_sel #(
    parameter int MAX_WAYS  = salru_pkg::MAX_WAYS_DEF,
    parameter int TAG_WIDTH = salru_pkg::TAG_WIDTH_DEF,
    parameter int RK_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
    input  logic [MAX_WAYS*(TAG_WIDTH+1)-1:0] i_tag_row,
    input  logic [MAX_WAYS*RK_W-1:0]          i_rank_row,
    input  logic [MAX_WAYS-1:0]               i_in_use,
    input  logic [TAG_WIDTH-1:0]              i_tag,
    output logic [MAX_WAYS*(TAG_WIDTH+1)-1:0] o_tag_row,
    output logic [MAX_WAYS*RK_W-1:0]          o_rank_row,
    output salru_pkg::t_look_res              o_res
);

    localparam int EW = TAG_WIDTH + 1;

    logic [RK_W-1:0]      w_rank  [MAX_WAYS];
    logic [MAX_WAYS-1:0]  w_valid;
    logic [MAX_WAYS-1:0]  w_match;
    logic [MAX_WAYS-1:0]  w_free;
    logic [MAX_WAYS-1:0]  w_hit_win;
    logic [MAX_WAYS-1:0]  w_free_win;
    logic [MAX_WAYS-1:0]  w_lru_win;
    logic [MAX_WAYS-1:0]  w_sel;
    logic [RK_W-1:0]      w_old;
    logic                 w_hit;
    logic                 w_fill;

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            w_rank[w]  = i_rank_row[w*RK_W +: RK_W];
            w_valid[w] = i_tag_row[w*EW + TAG_WIDTH];
            w_match[w] = i_in_use[w] && w_valid[w] &&
                         (i_tag_row[w*EW +: TAG_WIDTH] == i_tag);
            w_free[w]  = i_in_use[w] && !w_valid[w];
        end
    end

    // pairwise rank compares: smallest rank among matches or free ways, largest in use
    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            w_hit_win[w]  = w_match[w];
            w_free_win[w] = w_free[w];
            w_lru_win[w]  = i_in_use[w];
            for (int v = 0; v < MAX_WAYS; v++) begin
                if (v != w) begin
                    if (w_match[v] && (w_rank[v] < w_rank[w])) begin
                        w_hit_win[w] = 1'b0;
                    end
                    if (w_free[v] && (w_rank[v] < w_rank[w])) begin
                        w_free_win[w] = 1'b0;
                    end
                    if (i_in_use[v] && (w_rank[v] > w_rank[w])) begin
                        w_lru_win[w] = 1'b0;
                    end
                end
            end
        end
    end

    assign w_hit  = |w_match;
    assign w_fill = !w_hit && (|w_free);

    always_comb begin
        if (w_hit) begin
            w_sel = w_hit_win;
        end else if (w_fill) begin
            w_sel = w_free_win;
        end else begin
            w_sel = w_lru_win;
        end
    end

    always_comb begin
        w_old = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (w_sel[w]) begin
                w_old = w_old | w_rank[w];
            end
        end
    end

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (w_sel[w]) begin
                o_rank_row[w*RK_W +: RK_W] = '0;
            end else if (w_rank[w] < w_old) begin
                o_rank_row[w*RK_W +: RK_W] = w_rank[w] + RK_W'(1);
            end else begin
                o_rank_row[w*RK_W +: RK_W] = w_rank[w];
            end
            if (w_sel[w] && !w_hit) begin
                o_tag_row[w*EW +: EW] = {1'b1, i_tag};
            end else begin
                o_tag_row[w*EW +: EW] = i_tag_row[w*EW +: EW];
            end
        end
    end

    always_comb begin
        o_res.hit  = w_hit;
        o_res.fill = w_fill;
        if (w_hit) begin
            o_res.outcome = salru_pkg::OUT_HIT;
        end else if (w_fill) begin
            o_res.outcome = salru_pkg::OUT_FILL;
        end else begin
            o_res.outcome = salru_pkg::OUT_EVICT;
        end
    end

endmodule

// ===== rtl/core/set_assoc_lru_cache_model_unit.sv =====
// set-associative lru cache model: one hit/miss result per access.
// the access is registered into the lookup state, and the result strobe is registered from that state.
// a new access is taken only when idle: busy stays high during the read-modify-write of the set row.
// after reset a clearing pass over all 2**MAX_SET_BITS sets (64 by default) keeps busy high.
// the result strobe lasts one cycle and the receiver cannot stall it.
// depends on salru_pkg, salru_ram, salru_way_sel
module set_assoc_lru_cache_model_unit #(
    parameter int MAX_SET_BITS = salru_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = salru_pkg::MAX_WAYS_DEF,
    parameter int TAG_WIDTH    = salru_pkg::TAG_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [salru_pkg::CMD_W-1:0]         i_command,
    input  logic [salru_pkg::ADDR_W-1:0]        i_access_address,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [salru_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [salru_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                o_strobe,
    output logic [salru_pkg::OUTCOME_W-1:0]     o_outcome,
    output logic                                o_second_hit,
    output logic [salru_pkg::CNT_W-1:0]         o_hit_total,
    output logic [salru_pkg::CNT_W-1:0]         o_miss_total,
    output logic [salru_pkg::CNT_W-1:0]         o_eviction_total
);

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int SET_AW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int RK_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int EW       = TAG_WIDTH + 1;
    localparam int TROW_W   = MAX_WAYS * EW;
    localparam int RROW_W   = MAX_WAYS * RK_W;
    localparam int SB_W     = $clog2(MAX_SET_BITS + 8);
    localparam int SH_W     = $clog2(MAX_SET_BITS + 32);
    localparam int WC_W     = $clog2(MAX_WAYS + 16);
    localparam int CNT_W    = salru_pkg::CNT_W;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_LOOK  = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [salru_pkg::SBITS_W-1:0] r_cfg_sbits;
    logic [salru_pkg::WAYS_W-1:0]  r_cfg_ways;
    logic [salru_pkg::BOFF_W-1:0]  r_cfg_boff;

    logic [SET_AW-1:0]             r_clr_idx;
    logic [SET_AW-1:0]             r_set;
    logic [TAG_WIDTH-1:0]          r_tag;
    logic [MAX_WAYS-1:0]           r_in_use;
    logic                          r_modify;

    logic                          r_strobe;
    logic [salru_pkg::OUTCOME_W-1:0] r_outcome;
    logic                          r_second_hit;
    logic [CNT_W-1:0]              r_hit_cnt;
    logic [CNT_W-1:0]              r_miss_cnt;
    logic [CNT_W-1:0]              r_evict_cnt;

    logic                          w_accept;
    logic [SB_W-1:0]               w_sbits;
    logic [SH_W-1:0]               w_tag_shift;
    logic [salru_pkg::ADDR_W-1:0]  w_set_shifted;
    logic [salru_pkg::ADDR_W-1:0]  w_tag_shifted;
    logic [SET_AW-1:0]             w_set_mask;
    logic [SET_AW-1:0]             w_set;
    logic [WC_W-1:0]               w_ways;
    logic [MAX_WAYS-1:0]           w_in_use;

    logic                          w_we;
    logic [SET_AW-1:0]             w_waddr;
    logic [TROW_W-1:0]             w_tag_wdata;
    logic [RROW_W-1:0]             w_rank_wdata;
    logic [RROW_W-1:0]             w_rank_reset;
    logic [TROW_W-1:0]             w_tag_rdata;
    logic [RROW_W-1:0]             w_rank_rdata;
    logic [TROW_W-1:0]             w_tag_new;
    logic [RROW_W-1:0]             w_rank_new;
    salru_pkg::t_look_res          w_res;
    logic [1:0]                    w_hit_inc;

    assign busy        = (r_state != ST_IDLE);
    assign w_accept    = start && !busy;
    assign o_cfg_ready = 1'b1;

    // address split
    always_comb begin
        if (SB_W'(r_cfg_sbits) > SB_W'(MAX_SET_BITS)) begin
            w_sbits = SB_W'(MAX_SET_BITS);
        end else begin
            w_sbits = SB_W'(r_cfg_sbits);
        end
        w_tag_shift   = SH_W'(w_sbits) + SH_W'(r_cfg_boff);
        w_set_shifted = i_access_address >> r_cfg_boff;
        w_tag_shifted = i_access_address >> w_tag_shift;
        for (int b = 0; b < SET_AW; b++) begin
            w_set_mask[b] = (b < int'(w_sbits));
        end
        w_set = w_set_shifted[SET_AW-1:0] & w_set_mask;
    end

    always_comb begin
        if (r_cfg_ways == '0) begin
            w_ways = WC_W'(1);
        end else if (WC_W'(r_cfg_ways) > WC_W'(MAX_WAYS)) begin
            w_ways = WC_W'(MAX_WAYS);
        end else begin
            w_ways = WC_W'(r_cfg_ways);
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            w_in_use[w] = (w < int'(w_ways));
        end
    end

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            w_rank_reset[w*RK_W +: RK_W] = RK_W'(w);
        end
    end

    always_comb begin
        w_we         = 1'b0;
        w_waddr      = r_set;
        w_tag_wdata  = w_tag_new;
        w_rank_wdata = w_rank_new;
        if (r_state == ST_CLEAR) begin
            w_we         = 1'b1;
            w_waddr      = r_clr_idx;
            w_tag_wdata  = '0;
            w_rank_wdata = w_rank_reset;
        end else if (r_state == ST_LOOK) begin
            w_we = 1'b1;
        end
    end

    salru_ram #(
        .WIDTH  (TROW_W),
        .DEPTH  (NUM_SETS),
        .ADDR_W (SET_AW)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_tag_wdata),
        .i_raddr (w_set),
        .o_rdata (w_tag_rdata)
    );

    salru_ram #(
        .WIDTH  (RROW_W),
        .DEPTH  (NUM_SETS),
        .ADDR_W (SET_AW)
    ) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_rank_wdata),
        .i_raddr (w_set),
        .o_rdata (w_rank_rdata)
    );

    salru_way_sel #(
        .MAX_WAYS  (MAX_WAYS),
        .TAG_WIDTH (TAG_WIDTH),
        .RK_W      (RK_W)
    ) u_way_sel (
        .i_tag_row  (w_tag_rdata),
        .i_rank_row (w_rank_rdata),
        .i_in_use   (r_in_use),
        .i_tag      (r_tag),
        .o_tag_row  (w_tag_new),
        .o_rank_row (w_rank_new),
        .o_res      (w_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == SET_AW'(NUM_SETS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    assign w_hit_inc = 2'(w_res.hit) + 2'(r_modify);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_idx    <= '0;
            r_cfg_sbits  <= '0;
            r_cfg_ways   <= salru_pkg::WAYS_W'(1);
            r_cfg_boff   <= '0;
            r_strobe     <= 1'b0;
            r_hit_cnt    <= '0;
            r_miss_cnt   <= '0;
            r_evict_cnt  <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == ST_LOOK);
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + SET_AW'(1);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    salru_pkg::CFG_SET_BITS: r_cfg_sbits <= i_cfg_data[salru_pkg::SBITS_W-1:0];
                    salru_pkg::CFG_WAYS:     r_cfg_ways  <= i_cfg_data[salru_pkg::WAYS_W-1:0];
                    salru_pkg::CFG_OFFSET:   r_cfg_boff  <= i_cfg_data[salru_pkg::BOFF_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (r_state == ST_LOOK) begin
                r_hit_cnt <= r_hit_cnt + CNT_W'(w_hit_inc);
                if (!w_res.hit) begin
                    r_miss_cnt <= r_miss_cnt + CNT_W'(1);
                end
                if (!w_res.hit && !w_res.fill) begin
                    r_evict_cnt <= r_evict_cnt + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_set    <= w_set;
            r_tag    <= w_tag_shifted[TAG_WIDTH-1:0];
            r_in_use <= w_in_use;
            r_modify <= (i_command == salru_pkg::CMD_MODIFY);
        end
        if (r_state == ST_LOOK) begin
            r_outcome    <= w_res.outcome;
            r_second_hit <= r_modify;
        end
    end

    assign o_strobe         = r_strobe;
    assign o_outcome        = r_outcome;
    assign o_second_hit     = r_second_hit;
    assign o_hit_total      = r_hit_cnt;
    assign o_miss_total     = r_miss_cnt;
    assign o_eviction_total = r_evict_cnt;

    a_look_then_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOK) |=> o_strobe)
        else $error("lookup not followed by result strobe");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe lasted more than one cycle");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_we)
        else $error("memory write while idle");

    a_miss_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && o_strobe && (o_outcome != salru_pkg::OUT_HIT)
        |-> (o_miss_total == $past(o_miss_total) + CNT_W'(1)))
        else $error("miss count did not advance on a miss");

    a_evict_implies_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (o_eviction_total != $past(o_eviction_total))
        |-> (o_miss_total != $past(o_miss_total)))
        else $error("eviction counted without a miss");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking bench for set_assoc_lru_cache_model_unit: directed and random accesses
// over several cache geometries, each result checked against a behavioral lru cache model
// depends on salru_pkg and the cache unit rtl
module tb_top;

    localparam int MAX_SET_BITS_DEF = salru_pkg::MAX_SET_BITS_DEF;
    localparam int MAX_WAYS_DEF     = salru_pkg::MAX_WAYS_DEF;
    localparam int TAG_WIDTH_DEF    = salru_pkg::TAG_WIDTH_DEF;
    localparam int ADDR_W           = salru_pkg::ADDR_W;
    localparam int CMD_W            = salru_pkg::CMD_W;
    localparam int OUTCOME_W        = salru_pkg::OUTCOME_W;
    localparam int CNT_W            = salru_pkg::CNT_W;
    localparam int CFG_IDX_W        = salru_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W       = salru_pkg::CFG_DATA_W;
    localparam int SBITS_W          = salru_pkg::SBITS_W;
    localparam int WAYS_W           = salru_pkg::WAYS_W;
    localparam int BOFF_W           = salru_pkg::BOFF_W;

    localparam int NUM_SETS    = 1 << MAX_SET_BITS_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PRINT_LIMIT = 40;

    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STORE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [OUTCOME_W-1:0] outcome;
        logic                 second_hit;
        logic [CNT_W-1:0]     hits;
        logic [CNT_W-1:0]     misses;
        logic [CNT_W-1:0]     evictions;
    } t_access_result;

    logic                  i_clk;
    logic                  i_rst_n          = 1'b0;
    logic                  start            = 1'b0;
    logic                  busy;
    logic [CMD_W-1:0]      i_command        = '0;
    logic [ADDR_W-1:0]     i_access_address = '0;
    logic                  i_cfg_valid      = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;
    logic                  o_strobe;
    logic [OUTCOME_W-1:0]  o_outcome;
    logic                  o_second_hit;
    logic [CNT_W-1:0]      o_hit_total;
    logic [CNT_W-1:0]      o_miss_total;
    logic [CNT_W-1:0]      o_eviction_total;

    // cache model state
    logic                     line_valid [NUM_SETS][MAX_WAYS_DEF];
    logic [TAG_WIDTH_DEF-1:0] line_tag   [NUM_SETS][MAX_WAYS_DEF];
    int unsigned              line_rank  [NUM_SETS][MAX_WAYS_DEF];
    logic [CNT_W-1:0]         model_hits;
    logic [CNT_W-1:0]         model_misses;
    logic [CNT_W-1:0]         model_evictions;
    logic [SBITS_W-1:0]       cfg_set_bits;
    logic [WAYS_W-1:0]        cfg_ways;
    logic [BOFF_W-1:0]        cfg_offset;

    t_access_result expected_results[$];
    t_access_result oldest;
    int             mismatch_count = 0;
    int             cycle_count    = 0;

    set_assoc_lru_cache_model_unit DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_access_address (i_access_address),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_strobe         (o_strobe),
        .o_outcome        (o_outcome),
        .o_second_hit     (o_second_hit),
        .o_hit_total      (o_hit_total),
        .o_miss_total     (o_miss_total),
        .o_eviction_total (o_eviction_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int active_set_bits();
        return (cfg_set_bits > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : int'(cfg_set_bits);
    endfunction

    function automatic int active_ways();
        if (cfg_ways == 0)
            return 1;
        return (cfg_ways > MAX_WAYS_DEF) ? MAX_WAYS_DEF : int'(cfg_ways);
    endfunction

    function automatic t_access_result predict_access(input logic [CMD_W-1:0] cmd,
                                                      input logic [ADDR_W-1:0] addr);
        t_access_result           r;
        int                       sb;
        int                       nw;
        int                       s;
        int                       hit_way;
        int                       free_way;
        int                       lru_way;
        int                       way;
        int unsigned              old_rank;
        logic [ADDR_W-1:0]        above;
        logic [TAG_WIDTH_DEF-1:0] tag;
        sb = active_set_bits();
        nw = active_ways();
        s = int'((addr >> cfg_offset) & ((64'd1 << sb) - 64'd1));
        above = addr >> (sb + cfg_offset);
        tag = above[TAG_WIDTH_DEF-1:0];
        hit_way = -1;
        free_way = -1;
        lru_way = -1;
        for (int w = 0; w < nw; w++) begin
            if (line_valid[s][w]) begin
                if (line_tag[s][w] == tag &&
                    (hit_way < 0 || line_rank[s][w] < line_rank[s][hit_way]))
                    hit_way = w;
            end else if (free_way < 0 || line_rank[s][w] < line_rank[s][free_way]) begin
                free_way = w;
            end
            if (lru_way < 0 || line_rank[s][w] > line_rank[s][lru_way])
                lru_way = w;
        end
        if (hit_way >= 0) begin
            model_hits++;
            r.outcome = salru_pkg::OUT_HIT;
            way = hit_way;
        end else begin
            model_misses++;
            if (free_way >= 0) begin
                r.outcome = salru_pkg::OUT_FILL;
                way = free_way;
            end else begin
                model_evictions++;
                r.outcome = salru_pkg::OUT_EVICT;
                way = lru_way;
            end
            line_valid[s][way] = 1'b1;
            line_tag[s][way] = tag;
        end
        // touched way becomes most recent, younger ways age by one
        old_rank = line_rank[s][way];
        for (int w = 0; w < MAX_WAYS_DEF; w++)
            if (line_rank[s][w] < old_rank)
                line_rank[s][w]++;
        line_rank[s][way] = 0;
        r.second_hit = (cmd == salru_pkg::CMD_MODIFY);
        if (r.second_hit)
            model_hits++;
        r.hits = model_hits;
        r.misses = model_misses;
        r.evictions = model_evictions;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
                                   input logic [CNT_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: %s mismatch, got %0h expected %0h", $realtime, what, got, want);
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transaction outcome", CNT_W'(o_outcome), '0);
            end else begin
                oldest = expected_results.pop_front();
                if (o_outcome !== oldest.outcome)
                    report_mismatch("outcome", CNT_W'(o_outcome), CNT_W'(oldest.outcome));
                if (o_second_hit !== oldest.second_hit)
                    report_mismatch("second_hit", CNT_W'(o_second_hit),
                                    CNT_W'(oldest.second_hit));
                if (o_hit_total !== oldest.hits)
                    report_mismatch("hit_total", o_hit_total, oldest.hits);
                if (o_miss_total !== oldest.misses)
                    report_mismatch("miss_total", o_miss_total, oldest.misses);
                if (o_eviction_total !== oldest.evictions)
                    report_mismatch("eviction_total", o_eviction_total, oldest.evictions);
            end
        end
    end

    task automatic send_access(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr);
        start <= 1'b1;
        i_command <= cmd;
        i_access_address <= addr;
        @(negedge i_clk);
        while (busy !== 1'b0)
            @(negedge i_clk);
        @(posedge i_clk);
        expected_results.push_back(predict_access(cmd, addr));
    endtask

    task automatic issue_access(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                                input bit may_idle);
        if (may_idle && $urandom_range(99) < 28) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        send_access(cmd, addr);
    endtask

    task automatic drain_results(input int settle);
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        if ($urandom_range(99) < 28) begin
            i_cfg_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        while (o_cfg_ready !== 1'b1)
            @(negedge i_clk);
        @(posedge i_clk);
        case (idx)
            salru_pkg::CFG_SET_BITS: cfg_set_bits = data[SBITS_W-1:0];
            salru_pkg::CFG_WAYS:     cfg_ways = data[WAYS_W-1:0];
            salru_pkg::CFG_OFFSET:   cfg_offset = data[BOFF_W-1:0];
            default: ;
        endcase
    endtask

    // block must be idle: every result in and the pipeline settled
    task automatic set_geometry(input logic [CFG_DATA_W-1:0] sb,
                                input logic [CFG_DATA_W-1:0] ways,
                                input logic [CFG_DATA_W-1:0] boff);
        drain_results(4);
        write_register(salru_pkg::CFG_SET_BITS, sb);
        write_register(salru_pkg::CFG_WAYS, ways);
        write_register(salru_pkg::CFG_OFFSET, boff);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random_phase(input logic [CFG_DATA_W-1:0] sb,
                                    input logic [CFG_DATA_W-1:0] ways,
                                    input logic [CFG_DATA_W-1:0] boff,
                                    input int count, input bit may_idle);
        logic [ADDR_W-1:0] tag_pool [12];
        int                hot_set  [2];
        int                pool_n;
        int                sbits;
        int                sh;
        int                roll;
        int                set_part;
        logic [ADDR_W-1:0] addr;
        logic [CMD_W-1:0]  cmd;
        set_geometry(sb, ways, boff);
        sbits = active_set_bits();
        sh = sbits + cfg_offset;
        pool_n = active_ways() + $urandom_range(1, 3);
        foreach (tag_pool[i])
            tag_pool[i] = {$urandom, $urandom};
        hot_set[0] = $urandom_range((1 << sbits) - 1);
        hot_set[1] = $urandom_range((1 << sbits) - 1);
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 12) begin
                addr = {$urandom, $urandom};
            end else begin
                set_part = (roll < 70) ? hot_set[roll & 1] : $urandom_range((1 << sbits) - 1);
                addr = (tag_pool[$urandom_range(pool_n - 1)] << sh)
                     | (ADDR_W'(set_part) << cfg_offset)
                     | ({$urandom, $urandom} & ((64'd1 << cfg_offset) - 64'd1));
                // bits above the truncated tag must not matter
                if (roll < 22)
                    addr ^= {$urandom, $urandom} << (sh + TAG_WIDTH_DEF);
            end
            roll = $urandom_range(19);
            cmd = (roll < 6) ? CMD_LOAD : (roll < 12) ? CMD_STORE :
                  (roll < 19) ? salru_pkg::CMD_MODIFY : CMD_UNUSED;
            issue_access(cmd, addr, may_idle);
            if (may_idle && $urandom_range(199) == 0)
                drain_results(0);
        end
    endtask

    task automatic test_reset_geometry();
        issue_access(CMD_LOAD, 64'd0, 1'b1);
        issue_access(CMD_STORE, 64'd0, 1'b1);
        issue_access(salru_pkg::CMD_MODIFY, 64'd0, 1'b1);
        issue_access(CMD_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        issue_access(CMD_UNUSED, 64'hFFFF_FFFF_0000_0000, 1'b1);
        issue_access(CMD_LOAD, 64'd0, 1'b1);
    endtask

    // out-of-range set bits and ways clamp, widest offset
    task automatic test_extreme_geometry();
        set_geometry(5'd7, 5'd15, 5'd31);
        issue_access(CMD_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        issue_access(salru_pkg::CMD_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        issue_access(CMD_STORE, 64'h8000_0000_0000_0000, 1'b1);
        issue_access(CMD_LOAD, 64'h0000_001F_8000_0000, 1'b1);
    endtask

    // shrink then regrow the ways so that two ways hold the same tag
    task automatic test_duplicate_tags();
        set_geometry(5'd0, 5'd2, 5'd0);
        issue_access(CMD_LOAD, 64'h1234, 1'b1);
        issue_access(CMD_LOAD, 64'h5678, 1'b1);
        set_geometry(5'd0, 5'd1, 5'd0);
        issue_access(CMD_STORE, 64'h5678, 1'b1);
        set_geometry(5'd0, 5'd2, 5'd0);
        issue_access(CMD_LOAD, 64'h5678, 1'b1);
        issue_access(salru_pkg::CMD_MODIFY, 64'h5678, 1'b1);
    endtask

    task automatic test_zero_ways();
        set_geometry(5'd0, 5'd0, 5'd0);
        issue_access(CMD_LOAD, 64'h5678, 1'b1);
        issue_access(CMD_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    endtask

    task automatic test_random_geometries();
        run_random_phase(5'd6, 5'd8, 5'd31, 160, 1'b1);
        run_random_phase(5'd0, 5'd1, 5'd0, 160, 1'b1);
        run_random_phase(5'd7, 5'd15, 5'd0, 150, 1'b1);
        run_random_phase(5'd0, 5'd8, 5'd31, 150, 1'b1);
        repeat (6)
            run_random_phase(CFG_DATA_W'($urandom_range(31)), CFG_DATA_W'($urandom_range(31)),
                             CFG_DATA_W'($urandom_range(31)), 150, 1'b1);
    endtask

    task automatic test_back_to_back();
        run_random_phase(5'd3, 5'd4, 5'd2, 250, 1'b0);
    endtask

    initial begin
        foreach (line_valid[s, w]) begin
            line_valid[s][w] = 1'b0;
            line_tag[s][w] = '0;
            line_rank[s][w] = w;
        end
        model_hits = '0;
        model_misses = '0;
        model_evictions = '0;
        cfg_set_bits = '0;
        cfg_ways = 4'd1;
        cfg_offset = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_geometry();
        test_extreme_geometry();
        test_duplicate_tags();
        test_zero_ways();
        test_random_geometries();
        test_back_to_back();
        drain_results(4);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/salru_pkg.sv
rtl/core/salru_ram.sv
rtl/core/salru_way_sel.sv
rtl/core/set_assoc_lru_cache_model_unit.sv
bench/tb_top.sv
